// ===== design/lrs_pkg.sv =====
// lrs_pkg: sizes, bucket command types and the digit extraction function
// shared by the radix sorter modules
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lrs_pkg;

    localparam int KEY_W        = 32;
    localparam int MAX_KEYS     = 64;
    localparam int DIGIT_BITS   = 4;
    localparam int DIGIT_PASSES = 8;

    localparam int BUCKETS = 1 << DIGIT_BITS;
    localparam int CNT_W   = $clog2(MAX_KEYS + 1);
    localparam int ADDR_W  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int PASS_W  = (DIGIT_PASSES > 1) ? $clog2(DIGIT_PASSES) : 1;

    typedef enum logic [1:0] {
        BKT_IDLE,
        BKT_CLEAR,
        BKT_INC,
        BKT_SCAN
    } t_bkt_op;

    typedef struct packed {
        t_bkt_op               op;
        logic [DIGIT_BITS-1:0] digit;
    } t_bkt_ctl;

    function automatic logic [DIGIT_BITS-1:0] digit_of(
        input logic [KEY_W-1:0]  k,
        input logic [PASS_W-1:0] pass
    );
        int               s;
        logic [KEY_W-1:0] sh;
        s  = DIGIT_BITS * int'(pass);
        sh = (s >= KEY_W) ? '0 : (k >> s);
        return sh[DIGIT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/lsd_radix_sort_hex_digits.sv =====
// Stable LSD radix sort of up to 64 unsigned 32-bit keys, 4-bit digits, 8 passes.
// Keys load one per cycle into key memory A until a transfer with end_of_set;
// keys beyond 64 are dropped. Each pass clears the 16 bucket counters, counts the
// digits, runs the prefix scan and distributes the keys stably into the other key
// memory; the single read port of each key memory sets the one key per cycle in
// counting and distribution. Results then leave one at a time, each read issued
// only after the previous read data has returned and held while out_stall is set,
// the last one flagged by final_key. No input is taken while sorting or emitting.
// Depends on lrs_pkg, lrs_ram and lrs_buckets.
`timescale 1ns / 1ps
`default_nettype none

module lsd_radix_sort_hex_digits import lrs_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic             i_end_of_set,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic      [KEY_W-1:0] o_sorted_key,
    output logic                  o_final_key
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_CLEAR,
        S_COUNT,
        S_SCAN,
        S_DIST,
        S_OUT
    } t_state;

    localparam logic [PASS_W-1:0] PASS_LAST = PASS_W'(DIGIT_PASSES - 1);

    t_state                  r_state;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_idx;
    logic                    r_rd_vld;
    logic [PASS_W-1:0]       r_pass;
    logic                    r_src_b;
    logic [DIGIT_BITS-1:0]   r_scan;
    logic                    r_out_valid;
    logic [KEY_W-1:0]        r_out_key;
    logic                    r_out_final;

    logic                    in_xfer;
    logic                    out_xfer;
    logic                    room;
    logic                    more;
    logic                    run_issue;
    logic                    out_issue;
    logic                    dist_wr;
    logic [KEY_W-1:0]        a_rd;
    logic [KEY_W-1:0]        b_rd;
    logic [KEY_W-1:0]        src_data;
    logic                    a_we;
    logic [ADDR_W-1:0]       a_wa;
    logic [KEY_W-1:0]        a_wd;
    logic                    b_we;
    t_bkt_ctl                bkt_ctl;
    logic [CNT_W-1:0]        bkt_pos;

    assign o_in_stall   = (r_state != S_LOAD);
    assign o_out_valid  = r_out_valid;
    assign o_sorted_key = r_out_key;
    assign o_final_key  = r_out_final;

    assign in_xfer   = i_in_valid && (r_state == S_LOAD);
    assign out_xfer  = r_out_valid && !i_out_stall;
    assign room      = (r_count < CNT_W'(MAX_KEYS));
    assign more      = (r_idx < r_count);
    assign run_issue = ((r_state == S_COUNT) || (r_state == S_DIST)) && more;
    assign out_issue = (r_state == S_OUT) && more && !r_rd_vld
                       && (!r_out_valid || !i_out_stall);
    assign src_data  = r_src_b ? b_rd : a_rd;
    assign dist_wr   = (r_state == S_DIST) && r_rd_vld;

    assign a_we = (in_xfer && room) || (dist_wr && r_src_b);
    assign a_wa = (r_state == S_LOAD) ? r_count[ADDR_W-1:0] : bkt_pos[ADDR_W-1:0];
    assign a_wd = (r_state == S_LOAD) ? i_key : src_data;
    assign b_we = dist_wr && !r_src_b;

    always_comb begin
        bkt_ctl.op    = BKT_IDLE;
        bkt_ctl.digit = digit_of(src_data, r_pass);
        unique case (r_state)
            S_CLEAR: bkt_ctl.op = BKT_CLEAR;
            S_COUNT, S_DIST: begin
                if (r_rd_vld) begin
                    bkt_ctl.op = BKT_INC;
                end
            end
            S_SCAN: begin
                bkt_ctl.op    = BKT_SCAN;
                bkt_ctl.digit = r_scan;
            end
            default: bkt_ctl.op = BKT_IDLE;
        endcase
    end

    lrs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_mem_a (
        .i_clk     (i_clk),
        .i_wr_en   (a_we),
        .i_wr_addr (a_wa),
        .i_wr_data (a_wd),
        .i_rd_addr (r_idx[ADDR_W-1:0]),
        .o_rd_data (a_rd)
    );

    lrs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_mem_b (
        .i_clk     (i_clk),
        .i_wr_en   (b_we),
        .i_wr_addr (bkt_pos[ADDR_W-1:0]),
        .i_wr_data (src_data),
        .i_rd_addr (r_idx[ADDR_W-1:0]),
        .o_rd_data (b_rd)
    );

    lrs_buckets u_buckets (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (bkt_ctl),
        .o_pos   (bkt_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_pass      <= '0;
            r_src_b     <= 1'b0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (in_xfer) begin
                        if (room) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        if (i_end_of_set) begin
                            r_state <= S_CLEAR;
                        end
                    end
                end
                S_CLEAR: begin
                    r_state  <= S_COUNT;
                    r_idx    <= '0;
                    r_rd_vld <= 1'b0;
                end
                S_COUNT: begin
                    r_rd_vld <= run_issue;
                    if (run_issue) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    if (!more) begin
                        r_state <= S_SCAN;
                        r_scan  <= '0;
                    end
                end
                S_SCAN: begin
                    r_scan <= r_scan + DIGIT_BITS'(1);
                    if (r_scan == '1) begin
                        r_state <= S_DIST;
                        r_idx   <= '0;
                    end
                end
                S_DIST: begin
                    r_rd_vld <= run_issue;
                    if (run_issue) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    if (!more) begin
                        r_src_b <= !r_src_b;
                        r_idx   <= '0;
                        if (r_pass == PASS_LAST) begin
                            r_pass  <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_pass  <= r_pass + PASS_W'(1);
                            r_state <= S_CLEAR;
                        end
                    end
                end
                S_OUT: begin
                    r_rd_vld <= out_issue;
                    if (out_issue) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    if (out_xfer) begin
                        r_out_valid <= 1'b0;
                    end
                    if (r_rd_vld) begin
                        r_out_valid <= 1'b1;
                        r_out_key   <= src_data;
                        r_out_final <= (r_idx == r_count);
                    end
                    if (out_xfer && r_out_final) begin
                        r_state <= S_LOAD;
                        r_count <= '0;
                        r_idx   <= '0;
                        r_src_b <= 1'b0;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_KEYS))
        else $error("loaded key count beyond capacity");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("result pending while loading");

    a_dist_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIST) && r_rd_vld |-> (bkt_pos < r_count))
        else $error("distribution position beyond set size");

    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_final_key && !i_out_stall |=> !o_in_stall)
        else $error("not ready for a new set after the last transfer");
`endif

endmodule

`default_nettype wire

// ===== design/lrs_ram.sv =====
// lrs_ram: generic single write port, single read port ram
// read data registered; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lrs_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== design/lrs_buckets.sv =====
// lrs_buckets: bucket counters with clear, increment and exclusive prefix scan
// depends on lrs_pkg
`timescale 1ns / 1ps
`default_nettype none

module lrs_buckets import lrs_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_bkt_ctl         i_ctl,
    output logic      [CNT_W-1:0] o_pos
);

    logic [CNT_W-1:0] r_cnt [BUCKETS];
    logic [CNT_W-1:0] r_run;

    assign o_pos = r_cnt[i_ctl.digit];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUCKETS; i++) begin
                r_cnt[i] <= '0;
            end
            r_run <= '0;
        end else begin
            unique case (i_ctl.op)
                BKT_IDLE: begin
                end
                BKT_CLEAR: begin
                    for (int i = 0; i < BUCKETS; i++) begin
                        r_cnt[i] <= '0;
                    end
                    r_run <= '0;
                end
                BKT_INC: begin
                    r_cnt[i_ctl.digit] <= r_cnt[i_ctl.digit] + CNT_W'(1);
                end
                BKT_SCAN: begin
                    r_cnt[i_ctl.digit] <= r_run;
                    r_run              <= r_run + r_cnt[i_ctl.digit];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== tb/lsd_radix_sort_hex_digits_tb.sv =====
// lsd_radix_sort_hex_digits_tb: loads sets of keys, predicts the stable ascending
// order of each set and checks every sorted key and its final flag
// depends on lrs_pkg and lsd_radix_sort_hex_digits
`timescale 1ns / 1ps

module lsd_radix_sort_hex_digits_tb;
    import lrs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int END_SETTLE     = 200;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             end_of_set;
    } t_load_item;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             final_key;
    } t_sorted_item;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_in_valid   = 1'b0;
    logic [KEY_W-1:0] i_key        = '0;
    logic             i_end_of_set = 1'b0;
    logic             i_out_stall  = 1'b0;
    logic             o_in_stall;
    logic             o_out_valid;
    logic [KEY_W-1:0] o_sorted_key;
    logic             o_final_key;

    t_load_item       pending_loads[$];
    t_sorted_item     expected_sorted[$];
    logic [KEY_W-1:0] loaded_keys[$];
    logic [KEY_W-1:0] recent_key   = '0;
    int               idle_pct     = 0;
    int               stall_pct    = 0;
    int               mismatches   = 0;
    int               quiet_cycles = 0;

    lsd_radix_sort_hex_digits DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_key        (i_key),
        .i_end_of_set (i_end_of_set),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sorted_key (o_sorted_key),
        .o_final_key  (o_final_key)
    );

    always #5 i_clk = ~i_clk;

    function automatic int hex_digit(logic [KEY_W-1:0] k, int p);
        if (p * DIGIT_BITS >= KEY_W) return 0;
        return int'((k >> (p * DIGIT_BITS)) & (BUCKETS - 1));
    endfunction

    // counting distribution per digit, least significant first
    task automatic predict_sorted_set();
        logic [KEY_W-1:0] src[$];
        logic [KEY_W-1:0] dst[$];
        int               slot[BUCKETS];
        int               run, cnt, dgt, p, i, b;
        t_sorted_item     res;
        src = loaded_keys;
        for (p = 0; p < DIGIT_PASSES; p++) begin
            for (b = 0; b < BUCKETS; b++) slot[b] = 0;
            for (i = 0; i < src.size(); i++) slot[hex_digit(src[i], p)]++;
            run = 0;
            for (b = 0; b < BUCKETS; b++) begin
                cnt     = slot[b];
                slot[b] = run;
                run     = run + cnt;
            end
            dst = src;
            for (i = 0; i < src.size(); i++) begin
                dgt            = hex_digit(src[i], p);
                dst[slot[dgt]] = src[i];
                slot[dgt]++;
            end
            src = dst;
        end
        for (i = 0; i < src.size(); i++) begin
            res.key       = src[i];
            res.final_key = (i == src.size() - 1);
            expected_sorted.push_back(res);
        end
        loaded_keys.delete();
    endtask

    task automatic queue_load(logic [KEY_W-1:0] k, logic eos);
        t_load_item item;
        item.key        = k;
        item.end_of_set = eos;
        pending_loads.push_back(item);
    endtask

    // mix of narrow keys, high-digit keys, repeats and near repeats
    task automatic queue_random_set(int n);
        logic [KEY_W-1:0] k;
        int               i;
        for (i = 0; i < n; i++) begin
            case ($urandom_range(4))
                0: k = $urandom_range(15);
                1: k = ($urandom_range(15) << 28) | $urandom_range(15);
                2: k = recent_key;
                3: k = recent_key ^ (32'h1 << $urandom_range(31));
                default: k = $urandom();
            endcase
            recent_key = k;
            queue_load(k, i == n - 1);
        end
    endtask

    task automatic run_phase(int idle, int stall, int target, bit add_overflow);
        int queued, n;
        idle_pct  = idle;
        stall_pct = stall;
        queued    = 0;
        if (add_overflow) queue_random_set(MAX_KEYS + 2);
        while (queued < target) begin
            n = ($urandom_range(5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            if (n > target - queued) n = target - queued;
            queue_random_set(n);
            queued += n;
        end
        // sender holds off until every sorted key has come back
        while (pending_loads.size() > 0 || i_in_valid || expected_sorted.size() > 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : load_driver
        t_load_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pending_loads.size() > 0 && $urandom_range(99) >= idle_pct) begin
                nxt = pending_loads.pop_front();
                i_in_valid   <= 1'b1;
                i_key        <= nxt.key;
                i_end_of_set <= nxt.end_of_set;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // keys past capacity are dropped but their end flag still counts
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (loaded_keys.size() < MAX_KEYS) loaded_keys.push_back(i_key);
            if (i_end_of_set) predict_sorted_set();
        end
    end

    always @(posedge i_clk) begin : sorted_check
        t_sorted_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_sorted.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: key %h final %b", o_sorted_key, o_final_key);
            end else begin
                want = expected_sorted.pop_front();
                if (o_sorted_key !== want.key || o_final_key !== want.final_key) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected key %h final %b, got key %h final %b",
                                 want.key, want.final_key, o_sorted_key, o_final_key);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-key sets at both ends of the range
        queue_load(32'h0000_0000, 1'b1);
        queue_load(32'hFFFF_FFFF, 1'b1);
        // extremes mixed together
        queue_load(32'hFFFF_FFFF, 1'b0);
        queue_load(32'h0000_0000, 1'b0);
        queue_load(32'h8000_0000, 1'b0);
        queue_load(32'h0000_0001, 1'b0);
        queue_load(32'h7FFF_FFFF, 1'b0);
        queue_load(32'h0000_000F, 1'b0);
        queue_load(32'hF000_0000, 1'b1);
        // equal keys
        queue_load(32'h1234_5678, 1'b0);
        queue_load(32'h1234_5678, 1'b0);
        queue_load(32'h0000_0010, 1'b0);
        queue_load(32'h0000_0001, 1'b0);
        queue_load(32'h0000_0010, 1'b1);
        // only the top digit differs
        queue_load(32'h3000_0000, 1'b0);
        queue_load(32'h1000_0000, 1'b0);
        queue_load(32'h2000_0000, 1'b1);
        // already in order
        queue_load(32'h0000_0001, 1'b0);
        queue_load(32'h0000_0002, 1'b0);
        queue_load(32'h0000_0003, 1'b0);
        queue_load(32'h0000_0004, 1'b1);

        run_phase(0, 0, 6, 1'b0);
        run_phase(84, 0, 6, 1'b0);
        run_phase(0, 84, 6, 1'b0);
        run_phase(7, 7, 6, 1'b1);

        repeat (END_SETTLE) @(posedge i_clk);
        if (mismatches == 0 && expected_sorted.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
